>>> src/hfc_pkg.sv
`timescale 1ns / 1ps

package hfc_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 32;
  // ramp length, a power of two
  localparam int RAMP_LEVELS_DEF  = 1024;

  // fixed field widths of the result
  localparam int COLOR_W     = 8;
  localparam int INDEX_OUT_W = 10;

  // request kinds
  typedef enum logic {
    OP_MEASURE  = 1'b0,
    OP_COLORIZE = 1'b1
  } op_t;

  // quarter of the ramp that an index falls in
  typedef enum logic [1:0] {
    SEG_BLUE_CYAN    = 2'd0,
    SEG_CYAN_GREEN   = 2'd1,
    SEG_GREEN_YELLOW = 2'd2,
    SEG_YELLOW_RED   = 2'd3
  } ramp_seg_t;

  // status of the shared subtractor
  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage

>>> src/hfc_alu.sv
`timescale 1ns / 1ps

module hfc_alu import hfc_pkg::*; #(
  parameter int W = SAMPLE_WIDTH_DEF + 2
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] diff,
  output alu_flags_t          flags
);

  // one signed subtract serves every compare and every divide step
  assign diff       = a - b;
  assign flags.neg  = diff[W-1];
  assign flags.zero = (diff == '0);

endmodule

>>> src/hfc_ramp.sv
`timescale 1ns / 1ps

module hfc_ramp import hfc_pkg::*; #(
  parameter int RAMP_LEVELS = RAMP_LEVELS_DEF
) (
  input  logic [$clog2(RAMP_LEVELS)-1:0] idx,
  output logic [COLOR_W-1:0]             red,
  output logic [COLOR_W-1:0]             green,
  output logic [COLOR_W-1:0]             blue
);

  localparam int IDX_W = $clog2(RAMP_LEVELS);

  ramp_seg_t          seg;
  logic [IDX_W-3:0]   pos;
  logic [IDX_W+5:0]   pos_scaled;
  logic [COLOR_W-1:0] v;

  // segment from the top two bits, position inside it scaled to 0..255
  assign seg        = ramp_seg_t'(idx[IDX_W-1 -: 2]);
  assign pos        = idx[IDX_W-3:0];
  assign pos_scaled = {pos, 8'b0} >> (IDX_W - 2);
  assign v          = pos_scaled[COLOR_W-1:0];

  // blue-cyan-green-yellow-red ramp
  always_comb begin
    case (seg)
      SEG_BLUE_CYAN: begin
        red = '0; green = v; blue = '1;
      end
      SEG_CYAN_GREEN: begin
        red = '0; green = '1; blue = ~v;
      end
      SEG_GREEN_YELLOW: begin
        red = v; green = '1; blue = '0;
      end
      default: begin
        red = '1; green = ~v; blue = '0;
      end
    endcase
  end

endmodule

>>> src/heatmap_false_color.sv
`timescale 1ns / 1ps

// Min/max normalized false-color map. A measure request (op 0) folds its signed
// sample into the running frame minimum and maximum; new_frame on a measure
// request restarts tracking with that sample alone. A colorize request (op 1)
// returns color_index = floor(RAMP_LEVELS*(sample-min)/(max-min)), clamped to
// 0..RAMP_LEVELS-1 (0 for an empty or zero range, or a sample at or below the
// minimum), and the matching color on a blue-cyan-green-yellow-red ramp. Measure
// requests give no result. All compares and the restoring division run on one
// shared subtractor: a measure request holds the input through the min and max
// states (min alone with new_frame), a colorize request through the range,
// difference, check, divide and finish states, fewer when the index is settled
// by a compare. The result sits in an output register, so a finished result
// may wait while the next request is taken. RAMP_LEVELS must be a power of two.
module heatmap_false_color import hfc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int RAMP_LEVELS  = RAMP_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_new_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COLOR_W-1:0]             out_red,
  output logic [COLOR_W-1:0]             out_green,
  output logic [COLOR_W-1:0]             out_blue,
  output logic [INDEX_OUT_W-1:0]         out_color_index
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int AW    = SW + 2;
  localparam int IDX_W = $clog2(RAMP_LEVELS);
  localparam int CNT_W = $clog2(IDX_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MIN   = 8'b0000_0010,
    S_MAX   = 8'b0000_0100,
    S_RANGE = 8'b0000_1000,
    S_DIFF  = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // captured request
  logic signed [SW-1:0] sample_r;
  logic                 nf_r;

  // frame tracking
  logic signed [SW-1:0] min_r, min_nxt;
  logic signed [SW-1:0] max_r, max_nxt;

  // divider registers
  logic [SW-1:0]    range_r, range_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]     red_r, green_r, blue_r;
  logic [INDEX_OUT_W-1:0] cidx_r;

  logic signed [AW-1:0] alu_a, alu_b, alu_diff;
  alu_flags_t           alu_flags;

  logic [COLOR_W-1:0]         ramp_red, ramp_green, ramp_blue;
  logic [IDX_W+INDEX_OUT_W-1:0] idx_ext;
  logic                       in_take, out_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // operand select for the shared subtractor
  always_comb begin
    case (state_r)
      S_MIN: begin
        alu_a = AW'(sample_r); alu_b = AW'(min_r);
      end
      S_MAX: begin
        alu_a = AW'(max_r); alu_b = AW'(sample_r);
      end
      S_RANGE: begin
        alu_a = AW'(max_r); alu_b = AW'(min_r);
      end
      S_DIFF: begin
        alu_a = AW'(sample_r); alu_b = AW'(min_r);
      end
      S_CHK: begin
        alu_a = {2'b0, rem_r}; alu_b = {2'b0, range_r};
      end
      S_DIV: begin
        alu_a = {1'b0, rem_r, 1'b0}; alu_b = {2'b0, range_r};
      end
      default: begin
        alu_a = '0; alu_b = '0;
      end
    endcase
  end

  hfc_alu #(.W(AW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (alu_flags)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    range_nxt = range_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = (op_t'(in_op) == OP_MEASURE) ? S_MIN : S_RANGE;
        end
      end
      S_MIN: begin
        if (nf_r) begin
          min_nxt   = sample_r;
          max_nxt   = sample_r;
          state_nxt = S_IDLE;
        end else begin
          if (alu_flags.neg) min_nxt = sample_r;
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        if (alu_flags.neg) max_nxt = sample_r;
        state_nxt = S_IDLE;
      end
      S_RANGE: begin
        range_nxt = alu_diff[SW-1:0];
        if (alu_flags.neg || alu_flags.zero) begin
          idx_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        rem_nxt = alu_diff[SW-1:0];
        if (alu_flags.neg || alu_flags.zero) begin
          idx_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // sample at or past the maximum clamps to the top of the ramp
        if (!alu_flags.neg) begin
          idx_nxt   = '1;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring step: one quotient bit per cycle
        if (!alu_flags.neg) begin
          rem_nxt = alu_diff[SW-1:0];
        end else begin
          rem_nxt = {rem_r[SW-2:0], 1'b0};
        end
        idx_nxt = {idx_r[IDX_W-2:0], !alu_flags.neg};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(IDX_W - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  hfc_ramp #(.RAMP_LEVELS(RAMP_LEVELS)) u_ramp (
    .idx   (idx_r),
    .red   (ramp_red),
    .green (ramp_green),
    .blue  (ramp_blue)
  );

  assign idx_ext = {{INDEX_OUT_W{1'b0}}, idx_r};

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= {1'b0, {(SW-1){1'b1}}};
      max_r       <= {1'b1, {(SW-1){1'b0}}};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample;
      nf_r     <= in_new_frame;
    end
    range_r <= range_nxt;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    if (out_load) begin
      red_r   <= ramp_red;
      green_r <= ramp_green;
      blue_r  <= ramp_blue;
      cidx_r  <= idx_ext[INDEX_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_color_index = cidx_r;

  // a new result only comes out of the finishing step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finishing step");

  // divider remainder stays below the range
  a_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < range_r))
    else $error("divider remainder not below range");

  // an accepted request always starts the sequencer
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  // ramp colors never carry red and blue together
  a_ramp_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r == '0 || blue_r == '0))
    else $error("ramp color has both red and blue");

endmodule

>>> test/heatmap_false_color_test.sv
`timescale 1ns / 1ps

module heatmap_false_color_test;
  import hfc_pkg::*;

  localparam int SW      = SAMPLE_WIDTH_DEF;
  localparam int RAMP    = RAMP_LEVELS_DEF;
  localparam int QUARTER = RAMP / 4;
  localparam int N_REQ   = 1150;

  typedef struct {
    op_t                   op;
    logic signed [SW-1:0]  sample;
    logic                  new_frame;
    int                    gap_after;
    bit                    drain_first;
  } request_t;

  typedef struct {
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;
    logic [INDEX_OUT_W-1:0] pos;
  } color_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = 1'b0;
  logic signed [SW-1:0]  in_sample = '0;
  logic                  in_new_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic [INDEX_OUT_W-1:0] out_color_index;

  // predicted frame tracking state
  logic signed [SW-1:0] frame_lo = {1'b0, {(SW-1){1'b1}}};
  logic signed [SW-1:0] frame_hi = {1'b1, {(SW-1){1'b0}}};

  request_t pending_requests[$];
  color_t   expected_colors[$];

  bit req_taken;
  bit calm_phase;
  bit hold_done;
  int gap_left;
  int hold_left;
  int stall_left;
  int flow_left;
  int results_seen;
  int error_count;

  heatmap_false_color i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_sample       (in_sample),
    .in_new_frame    (in_new_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_color_index (out_color_index)
  );

  always #10 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_request(op_t op, logic signed [SW-1:0] s, logic nf, bit drain = 1'b0);
    request_t r;
    r.op          = op;
    r.sample      = s;
    r.new_frame   = nf;
    r.gap_after   = calm_phase ? 0 : idle_len();
    r.drain_first = drain;
    pending_requests.push_back(r);
  endtask

  // running min/max of the frame
  task automatic fold_sample(logic signed [SW-1:0] s, logic nf);
    if (nf) begin
      frame_lo = s;
      frame_hi = s;
    end else begin
      if (s < frame_lo) frame_lo = s;
      if (s > frame_hi) frame_hi = s;
    end
  endtask

  // normalized ramp position and its color
  function automatic color_t predict_color(logic signed [SW-1:0] s);
    longint sv;
    longint rng;
    longint d;
    int     idx;
    int     v;
    color_t c;
    sv  = s;
    idx = 0;
    if (frame_hi > frame_lo && sv > frame_lo) begin
      rng = longint'(frame_hi) - longint'(frame_lo);
      d   = sv - longint'(frame_lo);
      if (d >= rng) idx = RAMP - 1;
      else idx = int'((d * RAMP) / rng);
      if (idx > RAMP - 1) idx = RAMP - 1;
    end
    v = ((idx % QUARTER) * 256) / QUARTER;
    if (v > 255) v = 255;
    case (ramp_seg_t'(idx / QUARTER))
      SEG_BLUE_CYAN: begin
        c.red = 8'd0;  c.green = v[7:0];         c.blue = 8'd255;
      end
      SEG_CYAN_GREEN: begin
        c.red = 8'd0;  c.green = 8'd255;         c.blue = 8'(255 - v);
      end
      SEG_GREEN_YELLOW: begin
        c.red = v[7:0]; c.green = 8'd255;        c.blue = 8'd0;
      end
      default: begin
        c.red = 8'd255; c.green = 8'(255 - v);   c.blue = 8'd0;
      end
    endcase
    c.pos = idx[INDEX_OUT_W-1:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // accept requests and check results at the rising edge
  always @(posedge clk) begin : observe
    color_t want;
    if (rst_n && in_valid && !in_stall) begin
      req_taken = 1'b1;
      if (op_t'(in_op) == OP_MEASURE) fold_sample(in_sample, in_new_frame);
      else expected_colors.push_back(predict_color(in_sample));
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected result, index", out_color_index, 0);
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_color_index !== want.pos)
          report_mismatch("color_index", out_color_index, want.pos);
      end
    end
  end

  // request driver
  always @(negedge clk) begin : sender
    bit       drive;
    request_t cur;
    drive = in_valid;
    if (drive && req_taken) drive = 1'b0;
    req_taken = 1'b0;
    if (!drive && rst_n && pending_requests.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (!(pending_requests[0].drain_first && expected_colors.size() > 0)) begin
        cur = pending_requests.pop_front();
        in_op        <= cur.op;
        in_sample    <= cur.sample;
        in_new_frame <= cur.new_frame;
        gap_left     = cur.gap_after;
        drive        = 1'b1;
      end
    end
    in_valid <= drive;
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin : receiver
    bit hold;
    if (hold_left > 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 299;
      hold      = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      hold = 1'b0;
    end else begin
      flow_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 5);
      stall_left = idle_len();
      hold       = 1'b0;
    end
    out_stall <= hold;
  end

  // stimulus and end of run
  initial begin : stimulus
    longint               center;
    longint               mask;
    longint               lo;
    longint               hi;
    logic signed [SW-1:0] s;
    int                   pick;

    // nothing measured yet, new_frame ignored on colorize
    add_request(OP_COLORIZE, 32'sd0, 1'b0);
    add_request(OP_COLORIZE, 32'sh7FFFFFFF, 1'b1);
    // zero range
    add_request(OP_MEASURE, 32'sd6553600, 1'b1);
    add_request(OP_COLORIZE, 32'sd6553600, 1'b0);
    // full range, sample at the maximum and each quarter of the ramp
    add_request(OP_MEASURE, 32'sh80000000, 1'b0);
    add_request(OP_MEASURE, 32'sh7FFFFFFF, 1'b0);
    add_request(OP_COLORIZE, 32'sh7FFFFFFF, 1'b0);
    add_request(OP_COLORIZE, 32'sh80000000, 1'b0);
    add_request(OP_COLORIZE, -32'sd1610612736, 1'b0);
    add_request(OP_COLORIZE, -32'sd1073741824, 1'b0);
    add_request(OP_COLORIZE, 32'sd0, 1'b0);
    add_request(OP_COLORIZE, 32'sd1073741824, 1'b0);
    add_request(OP_COLORIZE, 32'sd2000000000, 1'b0);
    // small frame, samples below and above it
    add_request(OP_MEASURE, -32'sd1000, 1'b1, 1'b1);
    add_request(OP_MEASURE, 32'sd1000, 1'b0);
    add_request(OP_COLORIZE, -32'sd5000, 1'b0);
    add_request(OP_COLORIZE, 32'sd5000, 1'b0);
    add_request(OP_COLORIZE, -32'sd1000, 1'b0);
    add_request(OP_COLORIZE, 32'sd1000, 1'b0);
    add_request(OP_COLORIZE, 32'sd999, 1'b0);
    add_request(OP_COLORIZE, -32'sd999, 1'b0);
    add_request(OP_COLORIZE, -32'sd500, 1'b0);
    add_request(OP_COLORIZE, 32'sd500, 1'b0);

    // random frames: a restart, some measures, then colorize requests
    while (pending_requests.size() < N_REQ) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        center = longint'($signed($urandom));
        mask   = (longint'(1) << $urandom_range(0, 31)) - 1;
        s  = SW'(center + (longint'($urandom) & mask) - (mask >> 1));
        lo = s;
        hi = s;
        add_request(OP_MEASURE, s, 1'b1, $urandom_range(0, 19) == 0);
        repeat ($urandom_range(0, 6)) begin
          s = SW'(center + (longint'($urandom) & mask) - (mask >> 1));
          if (s < lo) lo = s;
          if (s > hi) hi = s;
          add_request(OP_MEASURE, s, 1'b0);
        end
        repeat ($urandom_range(1, 12)) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) s = SW'(lo);
          else if (pick < 16) s = SW'(hi);
          else if (pick < 24) s = $urandom;
          else s = SW'(center + (longint'($urandom) & mask) - (mask >> 1));
          add_request(OP_COLORIZE, s, $urandom_range(0, 1) == 1);
        end
      end else begin
        // noise
        repeat ($urandom_range(1, 5))
          add_request(op_t'($urandom_range(0, 1)), $urandom, $urandom_range(0, 3) == 0);
      end
    end
    calm_phase = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch("results left over", expected_colors.size(), 0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
src/hfc_pkg.sv
src/hfc_alu.sv
src/hfc_ramp.sv
src/heatmap_false_color.sv
test/heatmap_false_color_test.sv
